FILE: design/m4ct_pkg.sv
// ----------------------------------------------------------------------------
// m4ct_pkg
// Shared types and constants of the 4x4 fixed-point transform unit.
// ----------------------------------------------------------------------------
package m4ct_pkg;

	localparam int DATA_W        = 32;
	localparam int PROD_W        = 2 * DATA_W;
	localparam int ACC_W         = PROD_W + 2;
	localparam int MAT_N         = 4;
	localparam int ROW_W         = $clog2(MAT_N);
	localparam int FRAC_BITS_DEF = 16;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic [ROW_W-1:0]         row_t;

	typedef enum logic [2:0] {
		OP_LOAD_CUR  = 3'd0,
		OP_LOAD_OPR  = 3'd1,
		OP_COMPOSE   = 3'd2,
		OP_TRANSFORM = 3'd3,
		OP_IDENTITY  = 3'd4,
		OP_READ      = 3'd5
	} op_t;

	localparam logic KIND_VEC  = 1'b0;
	localparam logic KIND_ELEM = 1'b1;

	// one multiply-accumulate step handed to the lanes
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} mac_step_t;

endpackage

FILE: design/m4ct_in_if.sv
// ----------------------------------------------------------------------------
// m4ct_in_if
// Input channel of the transform unit: op, element and vector payload.
// ----------------------------------------------------------------------------
interface m4ct_in_if import m4ct_pkg::*; ();

	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [3:0]  elem_index;
	word_t       elem_value;
	word_t       vec_x;
	word_t       vec_y;
	word_t       vec_z;
	word_t       vec_w;

	modport source (
		output valid, op, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
		input  ready
	);

	modport sink (
		input  valid, op, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
		output ready
	);

endinterface

FILE: design/m4ct_out_if.sv
// ----------------------------------------------------------------------------
// m4ct_out_if
// Result channel of the transform unit: vector or element read back.
// ----------------------------------------------------------------------------
interface m4ct_out_if import m4ct_pkg::*; ();

	logic  valid;
	logic  ready;
	word_t res_x;
	word_t res_y;
	word_t res_z;
	word_t res_w;
	logic  res_kind;

	modport source (
		output valid, res_x, res_y, res_z, res_w, res_kind,
		input  ready
	);

	modport sink (
		input  valid, res_x, res_y, res_z, res_w, res_kind,
		output ready
	);

endinterface

FILE: design/m4ct_lane.sv
// ----------------------------------------------------------------------------
// m4ct_lane
// One column lane: registered 32x32 product, then exact 66-bit accumulation.
// ----------------------------------------------------------------------------
module m4ct_lane import m4ct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  mac_step_t step,
	input  word_t     a,
	input  word_t     b,
	output acc_t      acc,
	output logic      done
);

	prod_t     prod_s1;
	mac_step_t step_s1;
	acc_t      acc_s2;
	logic      done_s2;
	acc_t      prod_ext;

	assign prod_ext = acc_t'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1 <= '0;
			done_s2 <= 1'b0;
		end else begin
			step_s1 <= step;
			done_s2 <= step_s1.vld && step_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_t'(a) * prod_t'(b);
		if (step_s1.vld) begin
			if (step_s1.first) begin
				acc_s2 <= prod_ext;
			end else begin
				acc_s2 <= acc_s2 + prod_ext;
			end
		end
	end

	assign acc  = acc_s2;
	assign done = done_s2;

endmodule

FILE: design/m4ct_merge.sv
// ----------------------------------------------------------------------------
// m4ct_merge
// Collects the lane sums, rounds half up to the fraction width and saturates.
// ----------------------------------------------------------------------------
module m4ct_merge import m4ct_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  acc_t  acc [MAT_N],
	input  logic  done_in,
	output word_t res [MAT_N],
	output logic  done
);

	localparam acc_t HALF    = acc_t'(1) <<< (FRAC_BITS - 1);
	localparam acc_t SAT_MAX = acc_t'({1'b0, {(DATA_W-1){1'b1}}});
	localparam acc_t SAT_MIN = -(SAT_MAX + acc_t'(1));

	word_t res_s3 [MAT_N];
	logic  done_s3;
	word_t rnd    [MAT_N];
	acc_t  shifted[MAT_N];

	always_comb begin
		for (int i = 0; i < MAT_N; i++) begin
			shifted[i] = (acc[i] + HALF) >>> FRAC_BITS;
			if (shifted[i] > SAT_MAX) begin
				rnd[i] = SAT_MAX[DATA_W-1:0];
			end else if (shifted[i] < SAT_MIN) begin
				rnd[i] = SAT_MIN[DATA_W-1:0];
			end else begin
				rnd[i] = shifted[i][DATA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s3 <= 1'b0;
		end else begin
			done_s3 <= done_in;
		end
	end

	always_ff @(posedge clk) begin
		if (done_in) begin
			res_s3 <= rnd;
		end
	end

	assign res  = res_s3;
	assign done = done_s3;

endmodule

FILE: design/matrix4_compose_and_transform.sv
// ----------------------------------------------------------------------------
// matrix4_compose_and_transform
// 4x4 Q16.16 transform unit: element loads, compose, vector transform,
// identity and element read, computed by four column lanes.
// ----------------------------------------------------------------------------
// transform: the four k steps run through one multiplier per column lane,
//   then the merge; no new item is taken until the result is queued for output
// compose: four rows through the lanes and the merge, then a commit state
// read: delivered from the delivery state; loads and identity end on acceptance
// reset: arst_n clears both matrices to zero and empties the result register
// ----------------------------------------------------------------------------
module matrix4_compose_and_transform import m4ct_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	m4ct_in_if.sink           item,
	m4ct_out_if.source        result
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MAC  = 5'b00010,
		ST_WAIT = 5'b00100,
		ST_CMT  = 5'b01000,
		ST_DLV  = 5'b10000
	} state_t;

	localparam word_t ONE_VAL = word_t'(1) <<< FRAC_BITS;
	localparam row_t  K_LAST  = row_t'(MAT_N - 1);

	state_t    state_q;
	logic      cmp_q;
	row_t      k_q;
	row_t      row_q;
	word_t     cur_q  [MAT_N][MAT_N];
	word_t     opr_q  [MAT_N][MAT_N];
	word_t     new_q  [MAT_N][MAT_N];
	word_t     vec_q  [MAT_N];
	word_t     pend_q [MAT_N];
	logic      pend_kind_q;
	word_t     out_q  [MAT_N];
	logic      out_kind_q;
	logic      out_vld_q;

	logic      accept;
	logic      out_free;
	row_t      idx_row;
	row_t      idx_col;
	row_t      rd_row;
	word_t     cur_row[MAT_N];
	word_t     b_op;
	mac_step_t step;
	acc_t      lane_acc [MAT_N];
	logic      lane_done[MAT_N];
	logic      all_done;
	word_t     res      [MAT_N];
	logic      res_done;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign out_free   = !out_vld_q || result.ready;
	assign idx_row    = item.elem_index[3:2];
	assign idx_col    = item.elem_index[1:0];

	// a single row address serves both the lanes and element reads
	assign rd_row = (state_q == ST_IDLE) ? idx_row : k_q;

	always_comb begin
		for (int c = 0; c < MAT_N; c++) begin
			cur_row[c] = cur_q[rd_row][c];
		end
		b_op = cmp_q ? opr_q[row_q][k_q] : vec_q[k_q];
	end

	assign step.vld   = (state_q == ST_MAC);
	assign step.first = (k_q == '0);
	assign step.last  = (k_q == K_LAST);

	for (genvar g = 0; g < MAT_N; g++) begin : g_lane
		m4ct_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (step),
			.a      (cur_row[g]),
			.b      (b_op),
			.acc    (lane_acc[g]),
			.done   (lane_done[g])
		);
	end

	always_comb begin
		all_done = 1'b1;
		for (int i = 0; i < MAT_N; i++) begin
			all_done = all_done && lane_done[i];
		end
	end

	m4ct_merge #(
		.FRAC_BITS (FRAC_BITS)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (lane_acc),
		.done_in (all_done),
		.res     (res),
		.done    (res_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cmp_q     <= 1'b0;
			k_q       <= '0;
			row_q     <= '0;
			out_vld_q <= 1'b0;
			for (int r = 0; r < MAT_N; r++) begin
				for (int c = 0; c < MAT_N; c++) begin
					cur_q[r][c] <= '0;
					opr_q[r][c] <= '0;
				end
			end
		end else begin
			if (state_q == ST_DLV && out_free) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.op)
							OP_LOAD_CUR: cur_q[idx_row][idx_col] <= item.elem_value;
							OP_LOAD_OPR: opr_q[idx_row][idx_col] <= item.elem_value;
							OP_COMPOSE: begin
								cmp_q   <= 1'b1;
								k_q     <= '0;
								row_q   <= '0;
								state_q <= ST_MAC;
							end
							OP_TRANSFORM: begin
								cmp_q   <= 1'b0;
								k_q     <= '0;
								row_q   <= '0;
								state_q <= ST_MAC;
							end
							OP_IDENTITY: begin
								for (int r = 0; r < MAT_N; r++) begin
									for (int c = 0; c < MAT_N; c++) begin
										cur_q[r][c] <= (r == c) ? ONE_VAL : '0;
									end
								end
							end
							OP_READ: state_q <= ST_DLV;
							default: ;
						endcase
					end
				end
				ST_MAC: begin
					k_q <= k_q + row_t'(1);
					if (k_q == K_LAST) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (res_done) begin
						if (!cmp_q) begin
							state_q <= ST_DLV;
						end else if (row_q == K_LAST) begin
							state_q <= ST_CMT;
						end else begin
							row_q   <= row_q + row_t'(1);
							state_q <= ST_MAC;
						end
					end
				end
				ST_CMT: begin
					cur_q   <= new_q;
					state_q <= ST_IDLE;
				end
				ST_DLV: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.op == OP_TRANSFORM) begin
			vec_q[0] <= item.vec_x;
			vec_q[1] <= item.vec_y;
			vec_q[2] <= item.vec_z;
			vec_q[3] <= item.vec_w;
		end
		if (accept && item.op == OP_READ) begin
			pend_q[0]   <= cur_row[idx_col];
			for (int i = 1; i < MAT_N; i++) begin
				pend_q[i] <= '0;
			end
			pend_kind_q <= KIND_ELEM;
		end
		if (state_q == ST_WAIT && res_done) begin
			if (cmp_q) begin
				new_q[row_q] <= res;
			end else begin
				pend_q      <= res;
				pend_kind_q <= KIND_VEC;
			end
		end
		if (state_q == ST_DLV && out_free) begin
			out_q      <= pend_q;
			out_kind_q <= pend_kind_q;
		end
	end

	assign result.valid    = out_vld_q;
	assign result.res_x    = out_q[0];
	assign result.res_y    = out_q[1];
	assign result.res_z    = out_q[2];
	assign result.res_w    = out_q[3];
	assign result.res_kind = out_kind_q;

	// merged sums only come back while the sequencer waits for them
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		res_done |-> state_q == ST_WAIT)
		else $error("lane sums returned outside the wait state");

	a_mac_four_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAC && k_q == K_LAST |=> state_q == ST_WAIT && k_q == '0)
		else $error("multiply-accumulate loop did not end after four steps");

	a_transform_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.op == OP_TRANSFORM |=> state_q == ST_MAC && k_q == '0 && !cmp_q)
		else $error("accepted transform did not start the lanes");

	a_vec_to_dlv: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT && res_done && !cmp_q |=> state_q == ST_DLV
			&& pend_kind_q == KIND_VEC)
		else $error("transform result not queued for delivery");

	a_commit_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMT |-> cmp_q && row_q == K_LAST)
		else $error("compose commit before the last row");

endmodule

FILE: test/matrix4_compose_and_transform_tb.sv
// ----------------------------------------------------------------------------
// matrix4_compose_and_transform_tb
// Self-checking bench for the 4x4 fixed-point transform unit. A directed
// table covers reset contents, identity, saturation at both ends, unused op
// codes, loads of extreme values and compose. Random traffic follows, with
// matrix-load bursts and a long result stall. A model of the unit written
// here predicts every transform and read result.
// ----------------------------------------------------------------------------
module matrix4_compose_and_transform_tb import m4ct_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          FRAC        = FRAC_BITS_DEF;
	localparam int          ITEM_TARGET = 750;
	localparam int          LONG_HOLD   = 300;
	localparam int          DRAIN       = 40;
	localparam int          CYCLE_LIMIT = 400000;
	localparam logic [2:0]  OP_RSVD_6   = 3'd6;
	localparam logic [2:0]  OP_RSVD_7   = 3'd7;
	localparam word_t       W_MAX       = 32'sh7fff_ffff;
	localparam word_t       W_MIN       = 32'sh8000_0000;
	localparam word_t       W_ONE       = word_t'(1) <<< FRAC;

	typedef logic signed [67:0] wide_t;

	localparam wide_t SAT_HI = 68'sh7fff_ffff;
	localparam wide_t SAT_LO = -68'sh8000_0000;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
		word_t w;
		logic  kind;
	} vec_res_t;

	typedef struct {
		logic [2:0] op;
		logic [3:0] idx;
		word_t      val;
		word_t      x;
		word_t      y;
		word_t      z;
		word_t      w;
		bit         typed;
		vec_res_t   want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	m4ct_in_if  item_ch ();
	m4ct_out_if res_ch ();

	matrix4_compose_and_transform uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch)
	);

	word_t      cur_mat [16];
	word_t      opr_mat [16];
	vec_res_t   pending_results [$];
	stim_row_t  directed_rows [$];
	bit         typed_now;
	vec_res_t   typed_want;
	bit         quiet;
	bit         long_hold;
	int         fail_cnt;
	int         cycle_cnt;
	bit         got_one;
	vec_res_t   pred;
	vec_res_t   want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// rounded, saturated sum of four exact products
	function automatic word_t dot4(input word_t a0, a1, a2, a3, b0, b1, b2, b3);
		wide_t acc;
		acc = wide_t'(a0) * wide_t'(b0) + wide_t'(a1) * wide_t'(b1)
			+ wide_t'(a2) * wide_t'(b2) + wide_t'(a3) * wide_t'(b3)
			+ (wide_t'(1) <<< (FRAC - 1));
		acc = acc >>> FRAC;
		if (acc > SAT_HI)
			return W_MAX;
		if (acc < SAT_LO)
			return W_MIN;
		return word_t'(acc);
	endfunction

	task automatic xform_predict(input logic [2:0] op, input logic [3:0] idx,
		input word_t val, x, y, z, w, output bit has, output vec_res_t r);
		word_t nw [16];
		has = 1'b0;
		r = '0;
		case (op)
			OP_LOAD_CUR: cur_mat[idx] = val;
			OP_LOAD_OPR: opr_mat[idx] = val;
			OP_COMPOSE: begin
				for (int i = 0; i < 16; i++)
					nw[i] = dot4(opr_mat[i & 12], opr_mat[(i & 12) + 1],
						opr_mat[(i & 12) + 2], opr_mat[(i & 12) + 3],
						cur_mat[i & 3], cur_mat[(i & 3) + 4],
						cur_mat[(i & 3) + 8], cur_mat[(i & 3) + 12]);
				for (int i = 0; i < 16; i++)
					cur_mat[i] = nw[i];
			end
			OP_TRANSFORM: begin
				has = 1'b1;
				r.x = dot4(cur_mat[0], cur_mat[4], cur_mat[8], cur_mat[12], x, y, z, w);
				r.y = dot4(cur_mat[1], cur_mat[5], cur_mat[9], cur_mat[13], x, y, z, w);
				r.z = dot4(cur_mat[2], cur_mat[6], cur_mat[10], cur_mat[14], x, y, z, w);
				r.w = dot4(cur_mat[3], cur_mat[7], cur_mat[11], cur_mat[15], x, y, z, w);
				r.kind = KIND_VEC;
			end
			OP_IDENTITY: begin
				for (int i = 0; i < 16; i++)
					cur_mat[i] = (i % 5 == 0) ? W_ONE : '0;
			end
			OP_READ: begin
				has = 1'b1;
				r.x = cur_mat[idx];
				r.kind = KIND_ELEM;
			end
			default: ;
		endcase
	endtask

	function automatic word_t rand_word();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0: return W_MAX;
					1: return W_MIN;
					2: return '0;
					3: return -32'sd1;
					default: return W_ONE;
				endcase
			end
			1, 2, 3, 4: return word_t'($urandom_range(0, 2**19 - 1)) - word_t'(2**18);
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic stim_row_t make_row(input logic [2:0] op, input logic [3:0] idx,
		input word_t val, x, y, z, w);
		stim_row_t s;
		s.op = op;
		s.idx = idx;
		s.val = val;
		s.x = x;
		s.y = y;
		s.z = z;
		s.w = w;
		s.typed = 1'b0;
		s.want = '0;
		return s;
	endfunction

	task automatic add_typed(input stim_row_t s, input word_t x, y, z, w, input logic kind);
		s.typed = 1'b1;
		s.want.x = x;
		s.want.y = y;
		s.want.z = z;
		s.want.w = w;
		s.want.kind = kind;
		directed_rows.push_back(s);
	endtask

	// one transaction on the item channel, after a random gap
	task automatic offer(input stim_row_t s);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 10);
		repeat (gap) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
		end
		@(negedge clk);
		item_ch.valid      <= 1'b1;
		item_ch.op         <= s.op;
		item_ch.elem_index <= s.idx;
		item_ch.elem_value <= s.val;
		item_ch.vec_x      <= s.x;
		item_ch.vec_y      <= s.y;
		item_ch.vec_z      <= s.z;
		item_ch.vec_w      <= s.w;
		typed_now  = s.typed;
		typed_want = s.want;
		do
			@(posedge clk);
		while (!item_ch.ready);
	endtask

	task automatic check_field(input string name, input logic signed [31:0] e, a);
		if (e !== a) begin
			$error("%s: expected %0d, got %0d", name, e, a);
			fail_cnt++;
		end
	endtask

	// prediction at input acceptance
	always @(posedge clk) begin
		if (arst_n && item_ch.valid && item_ch.ready) begin
			xform_predict(item_ch.op, item_ch.elem_index, item_ch.elem_value,
				item_ch.vec_x, item_ch.vec_y, item_ch.vec_z, item_ch.vec_w, got_one, pred);
			if (got_one)
				pending_results.push_back(typed_now ? typed_want : pred);
		end
	end

	// comparison at result acceptance
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction: res_x %0d kind %0d",
					res_ch.res_x, res_ch.res_kind);
				fail_cnt++;
			end else begin
				want = pending_results.pop_front();
				check_field("res_x", want.x, res_ch.res_x);
				check_field("res_y", want.y, res_ch.res_y);
				check_field("res_z", want.z, res_ch.res_z);
				check_field("res_w", want.w, res_ch.res_w);
				check_field("res_kind", 32'(want.kind), 32'(res_ch.res_kind));
			end
		end
	end

	// result side: random hold-off per transaction, plus one long stall on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				repeat (LONG_HOLD) begin
					@(negedge clk);
					res_ch.ready <= 1'b0;
				end
			end
			gap = quiet ? 0 : $urandom_range(0, 10);
			repeat (gap) begin
				@(negedge clk);
				res_ch.ready <= 1'b0;
			end
			@(negedge clk);
			res_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!res_ch.valid);
		end
	end

	initial begin
		cycle_cnt = 0;
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if (cycle_cnt >= CYCLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int n;
		int r;
		logic [2:0] bop;
		stim_row_t s;
		bit hold_sent;
		arst_n             = 1'b0;
		item_ch.valid      = 1'b0;
		item_ch.op         = OP_LOAD_CUR;
		item_ch.elem_index = '0;
		item_ch.elem_value = '0;
		item_ch.vec_x      = '0;
		item_ch.vec_y      = '0;
		item_ch.vec_z      = '0;
		item_ch.vec_w      = '0;
		res_ch.ready       = 1'b0;
		typed_now          = 1'b0;
		typed_want         = '0;
		quiet              = 1'b0;
		long_hold          = 1'b0;
		hold_sent          = 1'b0;
		fail_cnt           = 0;
		for (int i = 0; i < 16; i++) begin
			cur_mat[i] = '0;
			opr_mat[i] = '0;
		end

		// contents after reset
		add_typed(make_row(OP_READ, 4'd0, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX),
			'0, '0, '0, '0, KIND_ELEM);
		add_typed(make_row(OP_READ, 4'd15, '0, '0, '0, '0, '0), '0, '0, '0, '0, KIND_ELEM);
		add_typed(make_row(OP_TRANSFORM, 4'd0, '0, W_MAX, W_MIN, -32'sd1, W_ONE),
			'0, '0, '0, '0, KIND_VEC);
		// identity on the diagonal, zero elsewhere
		directed_rows.push_back(make_row(OP_IDENTITY, 4'd7, W_MIN, '0, '0, '0, '0));
		add_typed(make_row(OP_READ, 4'd0, '0, '0, '0, '0, '0), W_ONE, '0, '0, '0, KIND_ELEM);
		add_typed(make_row(OP_READ, 4'd5, '0, '0, '0, '0, '0), W_ONE, '0, '0, '0, KIND_ELEM);
		add_typed(make_row(OP_READ, 4'd1, '0, '0, '0, '0, '0), '0, '0, '0, '0, KIND_ELEM);
		add_typed(make_row(OP_TRANSFORM, 4'd3, '0, W_MAX, W_MIN, 32'sd1, -32'sd1),
			W_MAX, W_MIN, 32'sd1, -32'sd1, KIND_VEC);
		// saturation at both ends
		directed_rows.push_back(make_row(OP_LOAD_CUR, 4'd0, W_MAX, '0, '0, '0, '0));
		directed_rows.push_back(make_row(OP_LOAD_CUR, 4'd4, W_MAX, '0, '0, '0, '0));
		add_typed(make_row(OP_TRANSFORM, 4'd0, '0, W_MAX, W_MAX, '0, '0),
			W_MAX, W_MAX, '0, '0, KIND_VEC);
		add_typed(make_row(OP_TRANSFORM, 4'd0, '0, W_MIN, W_MIN, '0, '0),
			W_MIN, W_MIN, '0, '0, KIND_VEC);
		// unused codes leave everything alone
		directed_rows.push_back(make_row(OP_RSVD_6, 4'd0, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
		directed_rows.push_back(make_row(OP_RSVD_7, 4'd15, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
		add_typed(make_row(OP_READ, 4'd4, '0, '0, '0, '0, '0), W_MAX, '0, '0, '0, KIND_ELEM);
		// compose with an operand holding extremes
		directed_rows.push_back(make_row(OP_LOAD_OPR, 4'd0, W_MIN, '0, '0, '0, '0));
		directed_rows.push_back(make_row(OP_LOAD_OPR, 4'd5, W_ONE, '0, '0, '0, '0));
		directed_rows.push_back(make_row(OP_LOAD_OPR, 4'd15, W_MAX, '0, '0, '0, '0));
		directed_rows.push_back(make_row(OP_COMPOSE, 4'd0, '0, '0, '0, '0, '0));
		directed_rows.push_back(make_row(OP_READ, 4'd0, '0, '0, '0, '0, '0));
		directed_rows.push_back(make_row(OP_READ, 4'd15, '0, '0, '0, '0, '0));
		directed_rows.push_back(make_row(OP_TRANSFORM, 4'd0, '0,
			32'sh0001_8000, -32'sh0000_4000, 32'sh0002_0000, W_ONE));
		directed_rows.push_back(make_row(OP_LOAD_CUR, 4'd10, W_MIN, '0, '0, '0, '0));
		add_typed(make_row(OP_READ, 4'd10, '0, '0, '0, '0, '0), W_MIN, '0, '0, '0, KIND_ELEM);
		directed_rows.push_back(make_row(OP_COMPOSE, 4'd0, '0, '0, '0, '0, '0));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			offer(directed_rows[i]);

		n = 0;
		while (n < ITEM_TARGET) begin
			if (n % 60 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (n >= 300 && !hold_sent) begin
				// result side stalls long while items keep coming
				hold_sent = 1'b1;
				quiet = 1'b1;
				long_hold = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 4) begin
				// program a whole matrix in order
				bop = ($urandom_range(0, 1) == 0) ? OP_LOAD_CUR : OP_LOAD_OPR;
				for (int i = 0; i < 16; i++)
					offer(make_row(bop, 4'(i), rand_word(), rand_word(), rand_word(),
						rand_word(), rand_word()));
				n += 16;
			end else begin
				if (r < 18)
					bop = OP_LOAD_CUR;
				else if (r < 32)
					bop = OP_LOAD_OPR;
				else if (r < 37)
					bop = OP_COMPOSE;
				else if (r < 75)
					bop = OP_TRANSFORM;
				else if (r < 79)
					bop = OP_IDENTITY;
				else if (r < 94)
					bop = OP_READ;
				else
					bop = ($urandom_range(0, 1) == 0) ? OP_RSVD_6 : OP_RSVD_7;
				s = make_row(bop, 4'($urandom_range(0, 15)), rand_word(), rand_word(),
					rand_word(), rand_word(), rand_word());
				offer(s);
				if (bop != OP_RSVD_6 && bop != OP_RSVD_7)
					n++;
			end
		end
		@(negedge clk);
		item_ch.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fail_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
design/m4ct_pkg.sv
design/m4ct_in_if.sv
design/m4ct_out_if.sv
design/m4ct_lane.sv
design/m4ct_merge.sv
design/matrix4_compose_and_transform.sv
test/matrix4_compose_and_transform_tb.sv
